// ===== src/cpu85_pkg.sv =====
package cpu85_pkg;

    // Data memory geometry
    localparam int MEM_DEPTH = 65536;
    localparam int AW        = $clog2(MEM_DEPTH);

    // Operand kinds
    localparam logic [2:0] K_REG = 3'd0;
    localparam logic [2:0] K_MEM = 3'd1;

    // Register indexes
    localparam logic [2:0] R_A = 3'd0;
    localparam logic [2:0] R_B = 3'd1;
    localparam logic [2:0] R_D = 3'd3;
    localparam logic [2:0] R_H = 3'd5;
    localparam logic [2:0] R_L = 3'd6;

    // Flag bit positions inside the 5-bit flag store
    localparam int F_CY = 0;
    localparam int F_P  = 1;
    localparam int F_AC = 2;
    localparam int F_Z  = 3;
    localparam int F_S  = 4;

    typedef enum logic [5:0] {
        OP_MOV  = 6'd0,  OP_MVI  = 6'd1,  OP_LDA  = 6'd2,  OP_STA  = 6'd3,
        OP_LHLD = 6'd4,  OP_SHLD = 6'd5,  OP_XCHG = 6'd6,  OP_LXI  = 6'd7,
        OP_LDAX = 6'd8,  OP_STAX = 6'd9,  OP_ADD  = 6'd10, OP_ADC  = 6'd11,
        OP_ADI  = 6'd12, OP_ACI  = 6'd13, OP_SUB  = 6'd14, OP_SBB  = 6'd15,
        OP_SUI  = 6'd16, OP_SBI  = 6'd17, OP_INR  = 6'd18, OP_INX  = 6'd19,
        OP_DCR  = 6'd20, OP_DCX  = 6'd21, OP_DAD  = 6'd22, OP_DAA  = 6'd23,
        OP_ANA  = 6'd24, OP_ANI  = 6'd25, OP_XRA  = 6'd26, OP_XRI  = 6'd27,
        OP_ORA  = 6'd28, OP_ORI  = 6'd29, OP_CMP  = 6'd30, OP_CPI  = 6'd31,
        OP_RLC  = 6'd32, OP_RAL  = 6'd33, OP_RRC  = 6'd34, OP_RAR  = 6'd35,
        OP_CMA  = 6'd36, OP_CMC  = 6'd37, OP_STC  = 6'd38, OP_JMP  = 6'd39,
        OP_JNZ  = 6'd40, OP_JZ   = 6'd41, OP_JNC  = 6'd42, OP_JC   = 6'd43,
        OP_JPO  = 6'd44, OP_JPE  = 6'd45, OP_JP   = 6'd46, OP_JM   = 6'd47,
        OP_PUSH = 6'd48, OP_POP  = 6'd49, OP_HLT  = 6'd50
    } op_t;

    typedef logic [6:0][7:0] regs_t;

    typedef struct packed {
        logic [5:0]  op;
        logic [2:0]  first_kind;
        logic [15:0] first_value;
        logic [2:0]  second_kind;
        logic [15:0] second_value;
        logic [1:0]  instr_size;
    } item_t;

    typedef struct packed {
        regs_t       regs;
        logic [4:0]  flags;
        logic [15:0] pc;
        logic [15:0] sp;
        logic        halt;
    } arch_t;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] addr;
        logic [7:0]    data;
    } mem_wr_t;

    // Register read, index 7 reads zero
    function automatic logic [7:0] reg_rd(input regs_t r, input logic [2:0] i);
        logic [7:0] v;
        unique case (i)
            3'd0: v = r[0];
            3'd1: v = r[1];
            3'd2: v = r[2];
            3'd3: v = r[3];
            3'd4: v = r[4];
            3'd5: v = r[5];
            3'd6: v = r[6];
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pair_rd(input regs_t r, input logic [2:0] i);
        return {reg_rd(r, i), reg_rd(r, i + 3'd1)};
    endfunction

    function automatic logic [7:0] psw_byte(input logic [4:0] f);
        return {f[F_S], f[F_Z], 1'b0, f[F_AC], 1'b0, f[F_P], 1'b0, f[F_CY]};
    endfunction

    // Z, S, P from a result byte
    function automatic logic [4:0] szp(input logic [4:0] f, input logic [7:0] r);
        logic [4:0] o;
        o = f;
        o[F_Z] = (r == 8'h00);
        o[F_S] = r[7];
        o[F_P] = ~(^r);
        return o;
    endfunction

    // 8-bit add or subtract; returns {cy, ac, result}
    function automatic logic [9:0] alu8(input logic [7:0] x, input logic [7:0] y,
                                        input logic cin, input logic sub);
        logic [8:0] yy;
        logic [9:0] r;
        logic [4:0] n;
        logic       cy;
        logic       ac;
        if (sub)
        begin
            yy = 9'd256 - ({1'b0, y} + {8'b0, cin});
            r  = {2'b0, x} + {1'b0, yy};
            n  = {1'b0, x[3:0]} + {1'b0, yy[3:0]};
            cy = ~r[8];
            ac = ~n[4];
        end
        else
        begin
            yy = {1'b0, y};
            r  = {2'b0, x} + {1'b0, yy} + {9'b0, cin};
            n  = {1'b0, x[3:0]} + {1'b0, y[3:0]};
            cy = r[8];
            ac = n[4];
        end
        return {cy, ac, r[7:0]};
    endfunction

    // Address of the first memory access of an instruction
    function automatic logic [AW-1:0] addr_first(input item_t it, input arch_t s);
        logic [15:0] a;
        logic [15:0] v1;
        v1 = it.first_value;
        unique case (it.op)
            OP_LDA, OP_STA, OP_LHLD, OP_SHLD: a = v1;
            OP_LDAX, OP_STAX:
                a = (v1 == 16'd1 || v1 == 16'd3) ? pair_rd(s.regs, v1[2:0])
                                                 : {s.regs[R_H], s.regs[R_L]};
            OP_POP:  a = s.sp;
            default: a = {s.regs[R_H], s.regs[R_L]};
        endcase
        return a[AW-1:0];
    endfunction

endpackage

// ===== src/cpu85_if.sv =====
interface cpu85_in_if;
    logic        valid;
    logic        ready;
    logic [5:0]  op;
    logic [2:0]  first_kind;
    logic [15:0] first_value;
    logic [2:0]  second_kind;
    logic [15:0] second_value;
    logic [1:0]  instr_size;

    modport source (output valid, op, first_kind, first_value, second_kind,
                    second_value, instr_size, input ready);
    modport sink (input valid, op, first_kind, first_value, second_kind,
                  second_value, instr_size, output ready);
endinterface

interface cpu85_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  acc_out;
    logic [7:0]  psw_flags;
    logic [15:0] pc_out;
    logic [15:0] sp_out;
    logic        halted_out;
    logic        error_code;

    modport source (output valid, acc_out, psw_flags, pc_out, sp_out, halted_out,
                    error_code, input ready);
    modport sink (input valid, acc_out, psw_flags, pc_out, sp_out, halted_out,
                  error_code, output ready);
endinterface

// ===== src/cpu85_ram.sv =====
module cpu85_ram #(
    parameter int DEPTH = 256,
    parameter int ABITS = $clog2(DEPTH),
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [ABITS-1:0] addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, read data holds when not read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/cpu85_exec.sv =====
module cpu85_exec
    import cpu85_pkg::*;
(
    input  item_t              item,
    input  arch_t              cur,
    input  logic               phase2,
    input  logic [7:0]         mdata,
    input  logic [7:0]         lo,
    output arch_t              nxt,
    output logic               err,
    output logic               final_step,
    output mem_wr_t            wr,
    output logic               rd2_en,
    output logic [AW-1:0]      rd2_addr
);

    logic [7:0]  a;
    logic [15:0] hl;
    logic [15:0] v1;
    logic [15:0] v2;
    logic [7:0]  imm;
    logic [2:0]  k1;
    logic [2:0]  k2;
    logic [2:0]  p;
    logic        v1_pair;
    logic        src_bad;
    logic [7:0]  src_val;
    logic [9:0]  alu_r;
    logic [7:0]  x8;
    logic [15:0] w16;
    logic [16:0] sum17;
    logic [15:0] sp_m1;
    logic [15:0] sp_m2;
    logic [15:0] v1_p1;
    logic        jump;
    logic        taken;
    logic        fix;

    always_comb
    begin
        nxt        = cur;
        err        = 1'b0;
        jump       = 1'b0;
        taken      = 1'b0;
        fix        = 1'b0;
        final_step = 1'b1;
        wr         = '0;
        rd2_en     = 1'b0;
        rd2_addr   = '0;
        alu_r      = '0;
        x8         = '0;
        w16        = '0;
        sum17      = '0;

        a       = cur.regs[R_A];
        hl      = {cur.regs[R_H], cur.regs[R_L]};
        v1      = item.first_value;
        v2      = item.second_value;
        imm     = v1[7:0];
        k1      = item.first_kind;
        k2      = item.second_kind;
        p       = v1[2:0];
        v1_pair = (v1 == 16'd1) || (v1 == 16'd3) || (v1 == 16'd5);
        src_bad = (k1 == K_REG) && (v1 > 16'd6);
        src_val = (k1 == K_REG) ? reg_rd(cur.regs, p) : mdata;
        sp_m1   = cur.sp - 16'd1;
        sp_m2   = cur.sp - 16'd2;
        v1_p1   = v1 + 16'd1;

        if (!cur.halt)
        begin
            unique case (item.op)
                OP_MOV:
                begin
                    if ((k1 == K_MEM && k2 != K_REG) || (k2 == K_MEM && k1 != K_REG) ||
                        (k1 == K_REG && v1 > 16'd6) || (k2 == K_REG && v2 > 16'd6))
                        err = 1'b1;
                    else
                    begin
                        x8 = (k2 == K_REG) ? reg_rd(cur.regs, v2[2:0])
                                           : ((k2 == K_MEM) ? mdata : 8'h00);
                        if (k1 == K_REG)
                            nxt.regs[p] = x8;
                        else if (k1 == K_MEM)
                            wr = '{we: 1'b1, addr: hl[AW-1:0], data: x8};
                    end
                end
                OP_MVI:
                begin
                    if (k1 == K_REG)
                    begin
                        if (v1 > 16'd6)
                            err = 1'b1;
                        else
                            nxt.regs[p] = v2[7:0];
                    end
                    else
                        wr = '{we: 1'b1, addr: hl[AW-1:0], data: v2[7:0]};
                end
                OP_LDA:  nxt.regs[R_A] = mdata;
                OP_STA:  wr = '{we: 1'b1, addr: v1[AW-1:0], data: a};
                OP_LHLD:
                begin
                    if (!phase2)
                    begin
                        final_step = 1'b0;
                        rd2_en     = 1'b1;
                        rd2_addr   = v1_p1[AW-1:0];
                    end
                    else
                    begin
                        nxt.regs[R_L] = lo;
                        nxt.regs[R_H] = mdata;
                    end
                end
                OP_SHLD:
                begin
                    if (!phase2)
                    begin
                        final_step = 1'b0;
                        wr = '{we: 1'b1, addr: v1[AW-1:0], data: cur.regs[R_L]};
                    end
                    else
                        wr = '{we: 1'b1, addr: v1_p1[AW-1:0], data: cur.regs[R_H]};
                end
                OP_XCHG:
                begin
                    nxt.regs[R_H] = cur.regs[R_D];
                    nxt.regs[R_L] = cur.regs[R_D + 3'd1];
                    nxt.regs[R_D] = cur.regs[R_H];
                    nxt.regs[R_D + 3'd1] = cur.regs[R_L];
                end
                OP_LXI:
                begin
                    if (k1 == K_REG)
                    begin
                        if (!v1_pair)
                            err = 1'b1;
                        else
                        begin
                            nxt.regs[p]        = v2[15:8];
                            nxt.regs[p + 3'd1] = v2[7:0];
                        end
                    end
                    else
                        nxt.sp = v2;
                end
                OP_LDAX, OP_STAX:
                begin
                    if (v1 != 16'd1 && v1 != 16'd3)
                        err = 1'b1;
                    else if (item.op == OP_LDAX)
                        nxt.regs[R_A] = mdata;
                    else
                    begin
                        w16 = pair_rd(cur.regs, p);
                        wr = '{we: 1'b1, addr: w16[AW-1:0], data: a};
                    end
                end
                OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_CMP:
                begin
                    if (src_bad)
                        err = 1'b1;
                    else
                    begin
                        alu_r = alu8(a, src_val,
                                     (item.op == OP_ADC || item.op == OP_SBB) &&
                                     cur.flags[F_CY],
                                     item.op == OP_SUB || item.op == OP_SBB ||
                                     item.op == OP_CMP);
                        nxt.flags[F_CY] = alu_r[9];
                        nxt.flags[F_AC] = alu_r[8];
                        nxt.flags = szp(nxt.flags, alu_r[7:0]);
                        if (item.op != OP_CMP)
                            nxt.regs[R_A] = alu_r[7:0];
                    end
                end
                OP_ADI, OP_ACI, OP_SUI, OP_SBI, OP_CPI:
                begin
                    alu_r = alu8(a, imm,
                                 (item.op == OP_ACI || item.op == OP_SBI) && cur.flags[F_CY],
                                 item.op == OP_SUI || item.op == OP_SBI || item.op == OP_CPI);
                    nxt.flags[F_CY] = alu_r[9];
                    nxt.flags[F_AC] = alu_r[8];
                    nxt.flags = szp(nxt.flags, alu_r[7:0]);
                    if (item.op != OP_CPI)
                        nxt.regs[R_A] = alu_r[7:0];
                end
                OP_INR, OP_DCR:
                begin
                    if (src_bad)
                        err = 1'b1;
                    else
                    begin
                        if (item.op == OP_INR)
                        begin
                            x8 = src_val + 8'd1;
                            nxt.flags[F_AC] = (src_val[3:0] == 4'hF);
                        end
                        else
                        begin
                            x8 = src_val - 8'd1;
                            nxt.flags[F_AC] = (src_val[3:0] == 4'h0);
                        end
                        nxt.flags = szp(nxt.flags, x8);
                        if (k1 == K_REG)
                            nxt.regs[p] = x8;
                        else
                            wr = '{we: 1'b1, addr: hl[AW-1:0], data: x8};
                    end
                end
                OP_INX, OP_DCX:
                begin
                    if (k1 == K_REG)
                    begin
                        if (!v1_pair)
                            err = 1'b1;
                        else
                        begin
                            w16 = pair_rd(cur.regs, p) +
                                  ((item.op == OP_INX) ? 16'h0001 : 16'hFFFF);
                            nxt.regs[p]        = w16[15:8];
                            nxt.regs[p + 3'd1] = w16[7:0];
                        end
                    end
                    else
                        nxt.sp = cur.sp + ((item.op == OP_INX) ? 16'h0001 : 16'hFFFF);
                end
                OP_DAD:
                begin
                    if (k1 == K_REG && !v1_pair)
                        err = 1'b1;
                    else
                    begin
                        w16   = (k1 == K_REG) ? pair_rd(cur.regs, p) : cur.sp;
                        sum17 = {1'b0, w16} + {1'b0, hl};
                        nxt.flags[F_CY] = sum17[16];
                        nxt.regs[R_H]   = sum17[15:8];
                        nxt.regs[R_L]   = sum17[7:0];
                    end
                end
                OP_DAA:
                begin
                    x8  = a;
                    fix = (x8[3:0] > 4'd9) || cur.flags[F_AC];
                    if (fix)
                        x8 = x8 + 8'h06;
                    nxt.flags[F_AC] = fix;
                    fix = (x8[7:4] > 4'd9) || cur.flags[F_CY];
                    if (fix)
                        x8 = x8 + 8'h60;
                    nxt.flags[F_CY] = fix;
                    nxt.flags = szp(nxt.flags, x8);
                    nxt.regs[R_A] = x8;
                end
                OP_ANA, OP_XRA, OP_ORA, OP_ANI, OP_XRI, OP_ORI:
                begin
                    if (src_bad && (item.op == OP_ANA || item.op == OP_XRA ||
                                    item.op == OP_ORA))
                        err = 1'b1;
                    else
                    begin
                        x8 = (item.op == OP_ANA || item.op == OP_XRA || item.op == OP_ORA)
                             ? src_val : imm;
                        if (item.op == OP_ANA || item.op == OP_ANI)
                            x8 = a & x8;
                        else if (item.op == OP_XRA || item.op == OP_XRI)
                            x8 = a ^ x8;
                        else
                            x8 = a | x8;
                        nxt.flags[F_CY] = 1'b0;
                        nxt.flags[F_AC] = (item.op == OP_ANA || item.op == OP_ANI);
                        nxt.flags = szp(nxt.flags, x8);
                        nxt.regs[R_A] = x8;
                    end
                end
                OP_RLC:
                begin
                    nxt.flags[F_CY] = a[7];
                    nxt.regs[R_A]   = {a[6:0], a[7]};
                end
                OP_RAL:
                begin
                    nxt.flags[F_CY] = a[7];
                    nxt.regs[R_A]   = {a[6:0], cur.flags[F_CY]};
                end
                OP_RRC:
                begin
                    nxt.flags[F_CY] = a[0];
                    nxt.regs[R_A]   = {a[0], a[7:1]};
                end
                OP_RAR:
                begin
                    nxt.flags[F_CY] = a[0];
                    nxt.regs[R_A]   = {cur.flags[F_CY], a[7:1]};
                end
                OP_CMA: nxt.regs[R_A]   = ~a;
                OP_CMC: nxt.flags[F_CY] = ~cur.flags[F_CY];
                OP_STC: nxt.flags[F_CY] = 1'b1;
                OP_JMP, OP_JNZ, OP_JZ, OP_JNC, OP_JC, OP_JPO, OP_JPE, OP_JP, OP_JM:
                begin
                    unique case (item.op)
                        OP_JNZ:  taken = ~cur.flags[F_Z];
                        OP_JZ:   taken = cur.flags[F_Z];
                        OP_JNC:  taken = ~cur.flags[F_CY];
                        OP_JC:   taken = cur.flags[F_CY];
                        OP_JPO:  taken = ~cur.flags[F_P];
                        OP_JPE:  taken = cur.flags[F_P];
                        OP_JP:   taken = ~cur.flags[F_S];
                        OP_JM:   taken = cur.flags[F_S];
                        default: taken = 1'b1;
                    endcase
                    jump   = 1'b1;
                    nxt.pc = taken ? v1 : (cur.pc + 16'd3);
                end
                OP_PUSH:
                begin
                    if (k1 == K_REG && !v1_pair)
                        err = 1'b1;
                    else
                    begin
                        w16 = (k1 == K_REG) ? pair_rd(cur.regs, p)
                                            : {a, psw_byte(cur.flags)};
                        if (!phase2)
                        begin
                            final_step = 1'b0;
                            wr = '{we: 1'b1, addr: sp_m1[AW-1:0], data: w16[15:8]};
                        end
                        else
                        begin
                            wr = '{we: 1'b1, addr: sp_m2[AW-1:0], data: w16[7:0]};
                            nxt.sp = sp_m2;
                        end
                    end
                end
                OP_POP:
                begin
                    if (k1 == K_REG && !v1_pair)
                        err = 1'b1;
                    else if (!phase2)
                    begin
                        final_step = 1'b0;
                        rd2_en     = 1'b1;
                        w16        = cur.sp + 16'd1;
                        rd2_addr   = w16[AW-1:0];
                    end
                    else
                    begin
                        nxt.sp = cur.sp + 16'd2;
                        if (k1 == K_REG)
                        begin
                            nxt.regs[p]        = mdata;
                            nxt.regs[p + 3'd1] = lo;
                        end
                        else
                        begin
                            nxt.regs[R_A]   = mdata;
                            nxt.flags[F_CY] = lo[0];
                            nxt.flags[F_P]  = lo[2];
                            nxt.flags[F_AC] = lo[4];
                            nxt.flags[F_Z]  = lo[6];
                            nxt.flags[F_S]  = lo[7];
                        end
                    end
                end
                OP_HLT: nxt.halt = 1'b1;
                default: err = 1'b1;
            endcase

            if (err)
                nxt = cur;
            else if (!jump && !nxt.halt)
                nxt.pc = cur.pc + {14'b0, item.instr_size};
        end
    end

endmodule

// ===== src/cpu_8085_execute_unit.sv =====
// cpu_8085_execute_unit: executes one decoded 8085-style instruction per word.
//
// in_ch  (cpu85_in_if.sink): op, operand kinds and values, instruction size.
// out_ch (cpu85_out_if.source): A, PSW byte, PC, SP, halt bit and error code
//   after the instruction, one result word per input word, in order.
//
// Each word is accepted in S_TAKE, where the first data memory read is
// issued, and finishes in S_EX. LHLD, SHLD, PUSH and POP touch two bytes
// of the single-port data memory and add a second access step, S_EX2;
// the single memory port is what makes that step needed.
//
// After reset the data memory is swept to zero, one byte a cycle, over all
// MEM_DEPTH (65536) addresses before the first word is accepted.
// The result sits in an output register; if the receiver stalls, the next
// word is still accepted and waits in its final step until the output
// register is free. Once a HLT has executed every further word is ignored
// and reports the held state until reset.
module cpu_8085_execute_unit
    import cpu85_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    cpu85_in_if.sink     in_ch,
    cpu85_out_if.source  out_ch
);

    typedef enum logic [1:0] {S_CLEAR, S_TAKE, S_EX, S_EX2} state_t;

    state_t        state_reg;
    logic [AW-1:0] clr_reg;
    arch_t         arch_reg;
    item_t         item_reg;
    logic [7:0]    lo_reg;
    logic          out_valid_reg;
    logic [7:0]    acc_reg;
    logic [7:0]    psw_reg;
    logic [15:0]   pc_reg;
    logic [15:0]   sp_reg;
    logic          halted_reg;
    logic          err_reg;

    item_t         in_item;
    arch_t         nxt;
    logic          err;
    logic          final_step;
    mem_wr_t       wr;
    logic          rd2_en;
    logic [AW-1:0] rd2_addr;
    logic          out_free;
    logic          commit;
    logic          accept;
    logic          mem_en;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;

    assign in_item = '{op: in_ch.op, first_kind: in_ch.first_kind,
                       first_value: in_ch.first_value, second_kind: in_ch.second_kind,
                       second_value: in_ch.second_value, instr_size: in_ch.instr_size};

    assign in_ch.ready = (state_reg == S_TAKE);
    assign accept      = in_ch.valid && (state_reg == S_TAKE);
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign commit      = ((state_reg == S_EX) || (state_reg == S_EX2)) && final_step &&
                         out_free;

    cpu85_exec u_exec (
        .item       (item_reg),
        .cur        (arch_reg),
        .phase2     (state_reg == S_EX2),
        .mdata      (mem_rdata),
        .lo         (lo_reg),
        .nxt        (nxt),
        .err        (err),
        .final_step (final_step),
        .wr         (wr),
        .rd2_en     (rd2_en),
        .rd2_addr   (rd2_addr)
    );

    // Memory port selection
    always_comb
    begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = 8'h00;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_en   = 1'b1;
                mem_we   = 1'b1;
                mem_addr = clr_reg;
            end
            S_TAKE:
            begin
                mem_en   = accept;
                mem_addr = addr_first(in_item, arch_reg);
            end
            S_EX, S_EX2:
            begin
                if (rd2_en)
                begin
                    mem_en   = 1'b1;
                    mem_addr = rd2_addr;
                end
                else
                begin
                    mem_en    = wr.we && (!final_step || out_free);
                    mem_we    = 1'b1;
                    mem_addr  = wr.addr;
                    mem_wdata = wr.data;
                end
            end
            default: mem_en = 1'b0;
        endcase
    end

    cpu85_ram #(.DEPTH(MEM_DEPTH), .ABITS(AW), .WIDTH(8)) u_dmem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Sequencer, architectural state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            arch_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(MEM_DEPTH - 1))
                        state_reg <= S_TAKE;
                end
                S_TAKE:
                begin
                    if (accept)
                        state_reg <= S_EX;
                end
                S_EX, S_EX2:
                begin
                    if (!final_step)
                    begin
                        state_reg <= S_EX2;
                    end
                    else if (commit)
                    begin
                        arch_reg  <= nxt;
                        state_reg <= S_TAKE;
                    end
                end
                default: state_reg <= S_CLEAR;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_item;
        if (state_reg == S_EX && !final_step)
            lo_reg <= mem_rdata;
        if (commit)
        begin
            acc_reg    <= nxt.regs[R_A];
            psw_reg    <= psw_byte(nxt.flags);
            pc_reg     <= nxt.pc;
            sp_reg     <= nxt.sp;
            halted_reg <= nxt.halt;
            err_reg    <= err;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.acc_out    = acc_reg;
    assign out_ch.psw_flags  = psw_reg;
    assign out_ch.pc_out     = pc_reg;
    assign out_ch.sp_out     = sp_reg;
    assign out_ch.halted_out = halted_reg;
    assign out_ch.error_code = err_reg;

    // Second access step only follows the first
    a_ex2_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EX2) |-> ($past(state_reg) == S_EX || $past(state_reg) == S_EX2))
        else $error("second access step without first step");

    // An accepted word always enters execution
    a_accept_ex: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EX))
        else $error("accepted word did not start execution");

    // No result while the memory is being cleared
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !out_valid_reg)
        else $error("result during memory clear");

    // Halt is sticky until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        arch_reg.halt |=> arch_reg.halt)
        else $error("halt bit cleared");

    // A commit never overwrites a result still waiting
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> ($stable(pc_reg) && $stable(acc_reg)))
        else $error("waiting result overwritten");

endmodule
